// ----- rtl/bmd_pkg.sv -----
`default_nettype none
package bmd_pkg;

  localparam int FREQ_W  = 32;
  localparam int VAL_W   = 24;
  localparam int OPND_W  = VAL_W + 1;
  localparam int PROD_W  = 2 * OPND_W;
  localparam int DIVD_W  = PROD_W;
  localparam int QUO_W   = 26;
  localparam int DVSR_W  = OPND_W + 1;
  localparam int CNT_W   = $clog2(QUO_W + 1);
  localparam int SUM_W   = QUO_W + 2;
  localparam int IN_W    = FREQ_W + 2 * VAL_W;
  localparam int OUT_W   = 2 * FREQ_W + 2 * VAL_W;
  localparam int OUSER_W = 2;

  // 180 degrees in Q16.8
  localparam logic signed [OPND_W-1:0] HALF_TURN = 25'sd46080;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 24'sh800000;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SAT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SAT_MIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_FIN,
    ST_COMMIT
  } state_t;

  typedef enum logic {
    OP_GAIN,
    OP_PHASE
  } op_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_go;
    logic    div_load;
    logic    div_step;
    logic    fin;
    logic    commit;
    logic    emit;
    op_sel_t op;
  } cmd_t;

  typedef struct packed {
    logic seen;
    logic gain_cross;
    logic phase_cross;
    logic last;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
    logic signed [VAL_W-1:0] res;
    if (v > SUM_MAX) begin
      res = SAT_MAX;
    end else if (v < SUM_MIN) begin
      res = SAT_MIN;
    end else begin
      res = v[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bode_margin_detector_core.sv -----
// Flow: a point with no crossing passes from its transfer through check and commit
// until the block is ready again; each crossing on a point adds multiply, divider
// load, 26 steps of the radix-2 divider plus its done state, and finish. A last
// point waits in commit while an earlier result still waits in the output register.
// Reset: synchronous, active low; clears the sweep state and the output valid.
`default_nettype none
module bode_margin_detector_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // frequency[31:0], magnitude_db[55:32], phase_deg[79:56]
  input  wire logic [bmd_pkg::IN_W-1:0]      in_tdata,
  input  wire logic                          in_tlast,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // phase_margin[23:0], gain_crossover_freq[55:24], gain_margin[79:56],
  // phase_crossover_freq[111:80]
  output logic      [bmd_pkg::OUT_W-1:0]     out_tdata,
  // gain_crossing_found[0], phase_crossing_found[1]
  output logic      [bmd_pkg::OUSER_W-1:0]   out_tuser
);

  bmd_pkg::cmd_t  cmd;
  bmd_pkg::stat_t stat;

  bmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bmd_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- rtl/bmd_div.sv -----
`default_nettype none
module bmd_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic                        step,
  input  wire logic [bmd_pkg::DIVD_W-1:0]  dividend,
  input  wire logic [bmd_pkg::DVSR_W-1:0]  divisor,
  output logic      [bmd_pkg::QUO_W-1:0]   quo,
  output logic                             done
);

  logic [bmd_pkg::DVSR_W-1:0] rem_r, rem_nxt;
  logic [bmd_pkg::QUO_W-1:0]  num_r, num_nxt;
  logic [bmd_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [bmd_pkg::DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [bmd_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bmd_pkg::DVSR_W:0]   trial;
  logic [bmd_pkg::DVSR_W:0]   diff;

  assign trial = {rem_r, num_r[bmd_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      // upper dividend bits are known to be below the divisor
      rem_nxt  = bmd_pkg::DVSR_W'(dividend[bmd_pkg::DIVD_W-1:bmd_pkg::QUO_W]);
      num_nxt  = dividend[bmd_pkg::QUO_W-1:0];
      quo_nxt  = '0;
      dvsr_nxt = divisor;
      cnt_nxt  = '0;
    end else if (step) begin
      if (trial >= {1'b0, dvsr_r}) begin
        rem_nxt = diff[bmd_pkg::DVSR_W-1:0];
        quo_nxt = {quo_r[bmd_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[bmd_pkg::DVSR_W-1:0];
        quo_nxt = {quo_r[bmd_pkg::QUO_W-2:0], 1'b0};
      end
      num_nxt = {num_r[bmd_pkg::QUO_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
  end

  assign quo  = quo_r;
  assign done = (cnt_r == bmd_pkg::CNT_W'(bmd_pkg::QUO_W));

endmodule
`default_nettype wire

// ----- rtl/bmd_dpath.sv -----
`default_nettype none
module bmd_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bmd_pkg::IN_W-1:0]      in_tdata,
  input  wire logic                          in_tlast,
  input  wire bmd_pkg::cmd_t                 cmd,
  output bmd_pkg::stat_t                     stat,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [bmd_pkg::OUT_W-1:0]     out_tdata,
  output logic      [bmd_pkg::OUSER_W-1:0]   out_tuser
);

  localparam int VW = bmd_pkg::VAL_W;
  localparam int FW = bmd_pkg::FREQ_W;
  localparam int OW = bmd_pkg::OPND_W;

  // current point
  logic        [FW-1:0] cur_freq_r, cur_freq_nxt;
  logic signed [VW-1:0] cur_mag_r, cur_mag_nxt;
  logic signed [VW-1:0] cur_ph_r, cur_ph_nxt;
  logic                 cur_last_r, cur_last_nxt;

  // sweep state
  logic signed [VW-1:0] prev_mag_r, prev_mag_nxt;
  logic signed [VW-1:0] prev_ph_r, prev_ph_nxt;
  logic                 seen_r, seen_nxt;
  logic signed [VW-1:0] held_pm_r, held_pm_nxt;
  logic        [FW-1:0] held_gfreq_r, held_gfreq_nxt;
  logic signed [VW-1:0] held_gm_r, held_gm_nxt;
  logic        [FW-1:0] held_pfreq_r, held_pfreq_nxt;
  logic                 gfound_r, gfound_nxt;
  logic                 pfound_r, pfound_nxt;

  logic signed [bmd_pkg::PROD_W-1:0] prod_r, prod_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [bmd_pkg::OUT_W-1:0]        out_data_r, out_data_nxt;
  logic [bmd_pkg::OUSER_W-1:0]      out_user_r, out_user_nxt;

  logic signed [OW-1:0] ext_pm, ext_pp, ext_mag, ext_ph;
  logic signed [OW-1:0] pp_shift, ph_shift;
  logic signed [OW-1:0] op_a, op_b, denom;
  logic        [bmd_pkg::PROD_W-1:0] prod_abs;
  logic        [bmd_pkg::DIVD_W-1:0] dividend;
  logic        [bmd_pkg::DVSR_W-1:0] divisor;
  logic        [bmd_pkg::QUO_W-1:0]  quo;
  logic                              div_done;
  logic signed [bmd_pkg::SUM_W-1:0]  q_ext, q_sgn, sum_g, sum_p;

  assign ext_pm   = OW'(prev_mag_r);
  assign ext_pp   = OW'(prev_ph_r);
  assign ext_mag  = OW'(cur_mag_r);
  assign ext_ph   = OW'(cur_ph_r);
  assign pp_shift = ext_pp + bmd_pkg::HALF_TURN;
  assign ph_shift = ext_ph + bmd_pkg::HALF_TURN;

  always_comb begin
    unique case (cmd.op)
      bmd_pkg::OP_GAIN: begin
        op_a  = ext_pm;
        op_b  = ext_ph - ext_pp;
        denom = ext_pm - ext_mag;
      end
      bmd_pkg::OP_PHASE: begin
        op_a  = pp_shift;
        op_b  = ext_mag - ext_pm;
        denom = ext_pp - ext_ph;
      end
      default: begin
        op_a  = '0;
        op_b  = '0;
        denom = '0;
      end
    endcase
  end

  // round half away from zero: |n|/d rounded = floor((2|n| + d) / 2d)
  assign prod_abs = prod_r[bmd_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign dividend = {prod_abs[bmd_pkg::DIVD_W-2:0], 1'b0} + bmd_pkg::DIVD_W'($unsigned(denom));
  assign divisor  = {$unsigned(denom), 1'b0};

  bmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (dividend),
    .divisor  (divisor),
    .quo      (quo),
    .done     (div_done)
  );

  assign q_ext = $signed(bmd_pkg::SUM_W'(quo));
  assign q_sgn = prod_r[bmd_pkg::PROD_W-1] ? -q_ext : q_ext;
  assign sum_g = bmd_pkg::SUM_W'(bmd_pkg::HALF_TURN) + bmd_pkg::SUM_W'(prev_ph_r) + q_sgn;
  assign sum_p = -(bmd_pkg::SUM_W'(prev_mag_r) + q_sgn);

  always_comb begin
    cur_freq_nxt   = cur_freq_r;
    cur_mag_nxt    = cur_mag_r;
    cur_ph_nxt     = cur_ph_r;
    cur_last_nxt   = cur_last_r;
    prev_mag_nxt   = prev_mag_r;
    prev_ph_nxt    = prev_ph_r;
    seen_nxt       = seen_r;
    held_pm_nxt    = held_pm_r;
    held_gfreq_nxt = held_gfreq_r;
    held_gm_nxt    = held_gm_r;
    held_pfreq_nxt = held_pfreq_r;
    gfound_nxt     = gfound_r;
    pfound_nxt     = pfound_r;
    prod_nxt       = prod_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cmd.load_in) begin
      cur_freq_nxt = in_tdata[FW-1:0];
      cur_mag_nxt  = $signed(in_tdata[FW+VW-1:FW]);
      cur_ph_nxt   = $signed(in_tdata[FW+2*VW-1:FW+VW]);
      cur_last_nxt = in_tlast;
    end

    if (cmd.mul_go) begin
      prod_nxt = op_a * op_b;
    end

    if (cmd.fin) begin
      if (cmd.op == bmd_pkg::OP_GAIN) begin
        held_pm_nxt    = bmd_pkg::sat_val(sum_g);
        held_gfreq_nxt = cur_freq_r;
        gfound_nxt     = 1'b1;
      end else begin
        held_gm_nxt    = bmd_pkg::sat_val(sum_p);
        held_pfreq_nxt = cur_freq_r;
        pfound_nxt     = 1'b1;
      end
    end

    if (cmd.commit) begin
      prev_mag_nxt = cur_mag_r;
      prev_ph_nxt  = cur_ph_r;
      seen_nxt     = 1'b1;
    end

    // emit the sweep result, then start the next sweep from scratch
    if (cmd.emit) begin
      out_data_nxt   = {held_pfreq_r, held_gm_r, held_gfreq_r, held_pm_r};
      out_user_nxt   = {pfound_r, gfound_r};
      out_valid_nxt  = 1'b1;
      prev_mag_nxt   = '0;
      prev_ph_nxt    = '0;
      seen_nxt       = 1'b0;
      held_pm_nxt    = '0;
      held_gfreq_nxt = '0;
      held_gm_nxt    = '0;
      held_pfreq_nxt = '0;
      gfound_nxt     = 1'b0;
      pfound_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mag_r   <= '0;
      prev_ph_r    <= '0;
      seen_r       <= 1'b0;
      held_pm_r    <= '0;
      held_gfreq_r <= '0;
      held_gm_r    <= '0;
      held_pfreq_r <= '0;
      gfound_r     <= 1'b0;
      pfound_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      prev_mag_r   <= prev_mag_nxt;
      prev_ph_r    <= prev_ph_nxt;
      seen_r       <= seen_nxt;
      held_pm_r    <= held_pm_nxt;
      held_gfreq_r <= held_gfreq_nxt;
      held_gm_r    <= held_gm_nxt;
      held_pfreq_r <= held_pfreq_nxt;
      gfound_r     <= gfound_nxt;
      pfound_r     <= pfound_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_freq_r <= cur_freq_nxt;
    cur_mag_r  <= cur_mag_nxt;
    cur_ph_r   <= cur_ph_nxt;
    cur_last_r <= cur_last_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  always_comb begin
    stat.seen        = seen_r;
    stat.gain_cross  = (prev_mag_r > 24'sd0) && (cur_mag_r <= 24'sd0);
    stat.phase_cross = (pp_shift > 25'sd0) && (ph_shift <= 25'sd0);
    stat.last        = cur_last_r;
    stat.div_done    = div_done;
    stat.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ----- rtl/bmd_ctrl.sv -----
`default_nettype none
module bmd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire bmd_pkg::stat_t  stat,
  output bmd_pkg::cmd_t        cmd
);

  bmd_pkg::state_t  state_r, state_nxt;
  bmd_pkg::op_sel_t op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmd_pkg::ST_IDLE;
      op_r    <= bmd_pkg::OP_GAIN;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.op       = op_r;
    unique case (state_r)
      bmd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = bmd_pkg::ST_CHECK;
        end
      end
      bmd_pkg::ST_CHECK: begin
        priority if (stat.seen && stat.gain_cross) begin
          op_nxt    = bmd_pkg::OP_GAIN;
          state_nxt = bmd_pkg::ST_MUL;
        end else if (stat.seen && stat.phase_cross) begin
          op_nxt    = bmd_pkg::OP_PHASE;
          state_nxt = bmd_pkg::ST_MUL;
        end else begin
          state_nxt = bmd_pkg::ST_COMMIT;
        end
      end
      bmd_pkg::ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = bmd_pkg::ST_DLOAD;
      end
      bmd_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = bmd_pkg::ST_DIV;
      end
      bmd_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = bmd_pkg::ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      bmd_pkg::ST_FIN: begin
        cmd.fin = 1'b1;
        // gain crossing goes first; phase crossing on the same point follows
        if (op_r == bmd_pkg::OP_GAIN && stat.phase_cross) begin
          op_nxt    = bmd_pkg::OP_PHASE;
          state_nxt = bmd_pkg::ST_MUL;
        end else begin
          state_nxt = bmd_pkg::ST_COMMIT;
        end
      end
      bmd_pkg::ST_COMMIT: begin
        if (!stat.last) begin
          cmd.commit = 1'b1;
          state_nxt  = bmd_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          cmd.emit   = 1'b1;
          state_nxt  = bmd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bmd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
